// ===== design/i2cms_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C master sequencer package
// Shared types, codes and defaults for the sequencer and its write queue.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cms_pkg;

  // Default depth of the write data queue.
  localparam int unsigned WQ_DEPTH_DEF = 4;

  // Request codes on the input channel.
  localparam logic [1:0] REQ_TICK = 2'd0;
  localparam logic [1:0] REQ_CMD  = 2'd1;
  localparam logic [1:0] REQ_PUSH = 2'd2;

  // Transfer kinds.
  localparam logic [1:0] KIND_READ      = 2'd0;
  localparam logic [1:0] KIND_WRITE     = 2'd1;
  localparam logic [1:0] KIND_REG_READ  = 2'd2;
  localparam logic [1:0] KIND_REG_WRITE = 2'd3;

  // Most significant bit of a byte.
  localparam logic [7:0] BYTE_MSB = 8'h80;

  // Bus sequencing phases. Every send phase is followed by its acknowledge.
  typedef enum logic [4:0] {
    PH_IDLE        = 5'd0,
    PH_START_A     = 5'd1,
    PH_SEND_ADDR_A = 5'd2,
    PH_ACK_ADDR_A  = 5'd3,
    PH_SEND_REG    = 5'd4,
    PH_ACK_REG     = 5'd5,
    PH_START_B     = 5'd6,
    PH_SEND_ADDR_B = 5'd7,
    PH_ACK_ADDR_B  = 5'd8,
    PH_SEND_DATA   = 5'd9,
    PH_ACK_DATA    = 5'd10,
    PH_READ        = 5'd11,
    PH_MACK        = 5'd12,
    PH_STOP        = 5'd13,
    PH_WAIT_DATA   = 5'd14
  } phase_t;

  // Control from the sequencer to the write queue.
  typedef struct packed {
    logic push;
    logic pop;
  } wq_ctl_t;

endpackage

`default_nettype wire

// ===== design/i2c_master_sequencer.sv =====
// ----------------------------------------------------------------------------
// I2C master sequencer
// Steps an I2C master through start, address, register, data, acknowledge
// and stop intervals, one bus interval per tick transaction.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake             Contents
//   in_*      input      in_valid / in_ready   tick, command or write byte
//   out_*     output     out_valid / out_ready bus levels, read byte, status
//
// Every input transaction yields one result transaction in the cycle after
// its acceptance. A transaction is taken every cycle unless a held result is
// stalled by out_ready; the sequencer state and the result register are
// updated in the cycle of acceptance by one pass of logic. The result register
// is the only buffer: in_ready follows out_ready while a result is held. Reset
// (rst_n low, synchronous) returns to idle with an empty write queue.
`default_nettype none

module i2c_master_sequencer #(
  parameter int unsigned WRITE_QUEUE_DEPTH = i2cms_pkg::WQ_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] in_req_type,
  input  wire logic [1:0] in_transfer_kind,
  input  wire logic [6:0] in_target_address,
  input  wire logic [7:0] in_register_index,
  input  wire logic [7:0] in_byte_count,
  input  wire logic [7:0] in_write_data,
  input  wire logic       in_sda_sampled,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_scl_level,
  output logic            out_sda_level,
  output logic            out_sda_output_enable,
  output logic [7:0]      out_read_data,
  output logic            out_read_valid,
  output logic            out_transfer_done,
  output logic            out_transfer_ok,
  output logic            out_busy_res,
  output logic            out_data_wanted
);

  localparam int unsigned CW = $clog2(WRITE_QUEUE_DEPTH + 1);

  // Sequencer state.
  i2cms_pkg::phase_t phase_r, phase_nxt;
  logic [1:0] tick_r, tick_nxt;
  logic [2:0] bit_r, bit_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic [7:0] bytes_r, bytes_nxt;
  logic [1:0] kind_r, kind_nxt;
  logic [6:0] addr_r, addr_nxt;
  logic [7:0] reg_r, reg_nxt;
  logic       failed_r, failed_nxt;

  // Result register.
  logic       out_valid_r;
  logic       scl_r, scl_nxt;
  logic       sda_r, sda_nxt;
  logic       oe_r, oe_nxt;
  logic [7:0] rdata_r, rdata_nxt;
  logic       rvalid_r, rvalid_nxt;
  logic       done_r, done_nxt;
  logic       ok_r, ok_nxt;
  logic       busy_r, busy_nxt;
  logic       wanted_r, wanted_nxt;

  // Queue interface and step requests.
  i2cms_pkg::wq_ctl_t wq_ctl;
  logic [7:0]         q_head;
  logic [CW-1:0]      q_count;
  logic               accept;
  logic               do_data_step, do_read_step, do_enter;
  i2cms_pkg::phase_t  enter_ph;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  i2cms_wq #(
    .DEPTH(WRITE_QUEUE_DEPTH)
  ) u_wq (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (wq_ctl),
    .push_data(in_write_data),
    .head     (q_head),
    .count    (q_count)
  );

  // One pass over the accepted transaction: next state and result.
  always_comb begin
    phase_nxt  = phase_r;
    tick_nxt   = tick_r;
    bit_nxt    = bit_r;
    shift_nxt  = shift_r;
    bytes_nxt  = bytes_r;
    kind_nxt   = kind_r;
    addr_nxt   = addr_r;
    reg_nxt    = reg_r;
    failed_nxt = failed_r;
    scl_nxt    = 1'b0;
    sda_nxt    = 1'b0;
    oe_nxt     = 1'b0;
    rdata_nxt  = 8'h00;
    rvalid_nxt = 1'b0;
    done_nxt   = 1'b0;
    ok_nxt     = 1'b0;
    wanted_nxt = 1'b0;
    busy_nxt   = (phase_r != i2cms_pkg::PH_IDLE) || (in_req_type == i2cms_pkg::REQ_CMD);
    wq_ctl     = '0;
    do_data_step = 1'b0;
    do_read_step = 1'b0;
    do_enter     = 1'b0;
    enter_ph     = i2cms_pkg::PH_IDLE;

    if (in_req_type != i2cms_pkg::REQ_TICK) begin
      // Command and push transactions touch no bus levels.
      if (in_req_type == i2cms_pkg::REQ_CMD && phase_r == i2cms_pkg::PH_IDLE) begin
        kind_nxt   = in_transfer_kind;
        addr_nxt   = in_target_address;
        reg_nxt    = in_register_index;
        bytes_nxt  = in_byte_count;
        failed_nxt = 1'b0;
        do_enter   = 1'b1;
        enter_ph   = i2cms_pkg::PH_START_A;
      end else if (in_req_type == i2cms_pkg::REQ_PUSH) begin
        wq_ctl.push = 1'b1;
      end
    end else begin
      unique case (phase_r)
        i2cms_pkg::PH_IDLE: begin
          scl_nxt = 1'b1;
          sda_nxt = 1'b1;
        end
        i2cms_pkg::PH_START_A, i2cms_pkg::PH_START_B: begin
          oe_nxt  = 1'b1;
          scl_nxt = !tick_r[1];
          sda_nxt = (tick_r == 2'd0);
          if (tick_r[1]) begin
            do_enter = 1'b1;
            if (phase_r == i2cms_pkg::PH_START_A) begin
              shift_nxt = {addr_r, (kind_r == i2cms_pkg::KIND_READ)};
              enter_ph  = i2cms_pkg::PH_SEND_ADDR_A;
            end else begin
              shift_nxt = {addr_r, 1'b1};
              enter_ph  = i2cms_pkg::PH_SEND_ADDR_B;
            end
          end else begin
            tick_nxt = tick_r + 1'b1;
          end
        end
        i2cms_pkg::PH_SEND_ADDR_A, i2cms_pkg::PH_SEND_REG,
        i2cms_pkg::PH_SEND_ADDR_B, i2cms_pkg::PH_SEND_DATA: begin
          oe_nxt  = 1'b1;
          sda_nxt = (shift_r & i2cms_pkg::BYTE_MSB) != 8'h00;
          scl_nxt = (tick_r == 2'd1);
          if (tick_r[1]) begin
            shift_nxt = {shift_r[6:0], 1'b0};
            tick_nxt  = 2'd0;
            if (bit_r == 3'd7) begin
              do_enter = 1'b1;
              enter_ph = i2cms_pkg::phase_t'(phase_r + 5'd1);
            end else begin
              bit_nxt = bit_r + 1'b1;
            end
          end else begin
            tick_nxt = tick_r + 1'b1;
          end
        end
        i2cms_pkg::PH_ACK_ADDR_A, i2cms_pkg::PH_ACK_REG,
        i2cms_pkg::PH_ACK_ADDR_B, i2cms_pkg::PH_ACK_DATA: begin
          sda_nxt = 1'b1;
          if (tick_r == 2'd0) begin
            scl_nxt = 1'b1;
            if (in_sda_sampled) begin
              failed_nxt = 1'b1;
            end
            tick_nxt = 2'd1;
          end else if (failed_r) begin
            do_enter = 1'b1;
            enter_ph = i2cms_pkg::PH_STOP;
          end else if (phase_r == i2cms_pkg::PH_ACK_ADDR_A) begin
            if (kind_r == i2cms_pkg::KIND_READ) begin
              do_read_step = 1'b1;
            end else if (kind_r == i2cms_pkg::KIND_WRITE) begin
              do_data_step = 1'b1;
            end else begin
              shift_nxt = reg_r;
              do_enter  = 1'b1;
              enter_ph  = i2cms_pkg::PH_SEND_REG;
            end
          end else if (phase_r == i2cms_pkg::PH_ACK_REG) begin
            if (kind_r == i2cms_pkg::KIND_REG_READ) begin
              do_enter = 1'b1;
              enter_ph = i2cms_pkg::PH_START_B;
            end else begin
              do_data_step = 1'b1;
            end
          end else if (phase_r == i2cms_pkg::PH_ACK_ADDR_B) begin
            do_read_step = 1'b1;
          end else begin
            do_data_step = 1'b1;
          end
        end
        i2cms_pkg::PH_READ: begin
          sda_nxt = 1'b1;
          scl_nxt = !tick_r[1];
          if (tick_r == 2'd1) begin
            shift_nxt = {shift_r[6:0], in_sda_sampled};
          end
          if (tick_r[1]) begin
            tick_nxt = 2'd0;
            if (bit_r == 3'd7) begin
              rvalid_nxt = 1'b1;
              rdata_nxt  = shift_r;
              bytes_nxt  = bytes_r - 1'b1;
              do_enter   = 1'b1;
              enter_ph   = i2cms_pkg::PH_MACK;
            end else begin
              bit_nxt = bit_r + 1'b1;
            end
          end else begin
            tick_nxt = tick_r + 1'b1;
          end
        end
        i2cms_pkg::PH_MACK: begin
          oe_nxt  = 1'b1;
          sda_nxt = (bytes_r == 8'd0);
          scl_nxt = (tick_r == 2'd1);
          if (tick_r[1]) begin
            do_read_step = 1'b1;
          end else begin
            tick_nxt = tick_r + 1'b1;
          end
        end
        i2cms_pkg::PH_STOP: begin
          oe_nxt  = 1'b1;
          scl_nxt = 1'b1;
          sda_nxt = (tick_r != 2'd0);
          if (tick_r == 2'd0) begin
            tick_nxt = 2'd1;
          end else begin
            done_nxt = 1'b1;
            ok_nxt   = !failed_r;
            do_enter = 1'b1;
            enter_ph = i2cms_pkg::PH_IDLE;
          end
        end
        i2cms_pkg::PH_WAIT_DATA: begin
          oe_nxt  = 1'b1;
          sda_nxt = 1'b1;
          if (q_count == '0) begin
            wanted_nxt = 1'b1;
          end else begin
            do_data_step = 1'b1;
          end
        end
        default: begin
          scl_nxt  = 1'b1;
          sda_nxt  = 1'b1;
          do_enter = 1'b1;
          enter_ph = i2cms_pkg::PH_IDLE;
        end
      endcase
    end

    // Resolve the shared data and read steps into a phase entry.
    if (do_data_step) begin
      do_enter = 1'b1;
      if (bytes_r == 8'd0) begin
        enter_ph = i2cms_pkg::PH_STOP;
      end else if (q_count != '0) begin
        wq_ctl.pop = 1'b1;
        shift_nxt  = q_head;
        bytes_nxt  = bytes_r - 1'b1;
        enter_ph   = i2cms_pkg::PH_SEND_DATA;
      end else begin
        enter_ph = i2cms_pkg::PH_WAIT_DATA;
      end
    end
    if (do_read_step) begin
      do_enter = 1'b1;
      if (bytes_r == 8'd0) begin
        enter_ph = i2cms_pkg::PH_STOP;
      end else begin
        shift_nxt = 8'h00;
        enter_ph  = i2cms_pkg::PH_READ;
      end
    end
    if (do_enter) begin
      phase_nxt = enter_ph;
      tick_nxt  = 2'd0;
      bit_nxt   = 3'd0;
    end

    // Nothing changes without an accepted transaction.
    if (!accept) begin
      wq_ctl = '0;
    end
  end

  // Sequencer state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= i2cms_pkg::PH_IDLE;
      tick_r   <= '0;
      bit_r    <= '0;
      shift_r  <= '0;
      bytes_r  <= '0;
      kind_r   <= '0;
      addr_r   <= '0;
      reg_r    <= '0;
      failed_r <= 1'b0;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      tick_r   <= tick_nxt;
      bit_r    <= bit_nxt;
      shift_r  <= shift_nxt;
      bytes_r  <= bytes_nxt;
      kind_r   <= kind_nxt;
      addr_r   <= addr_nxt;
      reg_r    <= reg_nxt;
      failed_r <= failed_nxt;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      scl_r    <= scl_nxt;
      sda_r    <= sda_nxt;
      oe_r     <= oe_nxt;
      rdata_r  <= rdata_nxt;
      rvalid_r <= rvalid_nxt;
      done_r   <= done_nxt;
      ok_r     <= ok_nxt;
      busy_r   <= busy_nxt;
      wanted_r <= wanted_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_scl_level         = scl_r;
  assign out_sda_level         = sda_r;
  assign out_sda_output_enable = oe_r;
  assign out_read_data         = rdata_r;
  assign out_read_valid        = rvalid_r;
  assign out_transfer_done     = done_r;
  assign out_transfer_ok       = ok_r;
  assign out_busy_res          = busy_r;
  assign out_data_wanted       = wanted_r;

  // Idle always sits at the first interval and first bit.
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == i2cms_pkg::PH_IDLE) |-> (tick_r == 2'd0 && bit_r == 3'd0))
    else $error("idle phase with nonzero interval or bit counter");

  // A finished stop returns the sequencer to idle.
  a_stop_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_req_type == i2cms_pkg::REQ_TICK && phase_r == i2cms_pkg::PH_STOP &&
     tick_r == 2'd1) |=> (phase_r == i2cms_pkg::PH_IDLE && out_transfer_done))
    else $error("stop did not finish into idle");

  // A paused bus never reports a finished transfer or a read byte.
  a_wanted_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_wanted) |-> (!out_transfer_done && !out_read_valid &&
     !out_scl_level))
    else $error("data request together with bus activity");

  // The queue never holds more than its depth.
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= CW'(WRITE_QUEUE_DEPTH))
    else $error("write queue count beyond depth");

endmodule

`default_nettype wire

// ===== design/i2cms_wq.sv =====
// ----------------------------------------------------------------------------
// I2C master sequencer write queue
// Small FIFO of write data bytes; a push into a full queue is dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cms_wq #(
  parameter int unsigned DEPTH = i2cms_pkg::WQ_DEPTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire i2cms_pkg::wq_ctl_t         ctl,
  input  wire logic [7:0]                 push_data,
  output logic      [7:0]                 head,
  output logic      [$clog2(DEPTH+1)-1:0] count
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [7:0]    mem_r [DEPTH];
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          push_ok, pop_ok;

  // Qualify requests against the fill level.
  assign push_ok = ctl.push && (count_r != CW'(DEPTH));
  assign pop_ok  = ctl.pop && (count_r != '0);

  // Pointer wrap and fill count.
  always_comb begin
    rd_ptr_nxt = rd_ptr_r;
    wr_ptr_nxt = wr_ptr_r;
    count_nxt  = count_r;
    if (push_ok) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_ok) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push_ok && !pop_ok) begin
      count_nxt = count_r + 1'b1;
    end else if (pop_ok && !push_ok) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Data storage needs no reset; only counted entries are read.
  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign head  = mem_r[rd_ptr_r];
  assign count = count_r;

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// I2C master sequencer testbench
// Drives tick, command and write-byte transactions into the sequencer and checks
// every result transaction against a bus-level predictor kept in step with the
// accepted input, or against the table's expected result for typed rows. A short
// table of directed transfers runs first, then randomized transfers answered by
// a simulated target, under several patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------

module testbench;

  // Request code with no effect on the sequencer.
  localparam logic [1:0] REQ_NONE = 2'd3;
  localparam int unsigned RANDOM_ITEMS = 800;
  localparam int unsigned IDLE_PHASES = 5;

  typedef struct packed {
    logic [1:0] req;
    logic [1:0] kind;
    logic [6:0] addr;
    logic [7:0] regi;
    logic [7:0] count;
    logic [7:0] wdata;
    logic       sda;
  } bus_item_t;

  localparam int unsigned ITEM_W = $bits(bus_item_t);

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       oe;
    logic [7:0] rdata;
    logic       rvalid;
    logic       done;
    logic       ok;
    logic       busy;
    logic       wanted;
  } bus_res_t;

  // How the simulated target answers on SDA during tick transactions.
  typedef enum logic [2:0] {
    SDA_LOW,
    SDA_HIGH,
    SDA_ONES,
    SDA_TARGET,
    SDA_NOISE
  } sda_mode_t;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  typedef struct {
    bus_item_t   item;
    int unsigned reps;
    sda_mode_t   sda;
    logic        typed;
    bus_res_t    want;
  } stim_row_t;

  // Results that can be read off directly.
  localparam bus_res_t RES_NONE       = '0;
  localparam bus_res_t RES_BUSY       = '{busy: 1'b1, default: '0};
  localparam bus_res_t RES_IDLE_BUS   = '{scl: 1'b1, sda: 1'b1, default: '0};
  localparam bus_res_t RES_START_OPEN = '{scl: 1'b1, sda: 1'b1, oe: 1'b1, busy: 1'b1,
                                         default: '0};

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] in_req_type = '0;
  logic [1:0] in_transfer_kind = '0;
  logic [6:0] in_target_address = '0;
  logic [7:0] in_register_index = '0;
  logic [7:0] in_byte_count = '0;
  logic [7:0] in_write_data = '0;
  logic       in_sda_sampled = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_scl_level;
  logic       out_sda_level;
  logic       out_sda_output_enable;
  logic [7:0] out_read_data;
  logic       out_read_valid;
  logic       out_transfer_done;
  logic       out_transfer_ok;
  logic       out_busy_res;
  logic       out_data_wanted;

  // Predicted bus state.
  i2cms_pkg::phase_t bp_phase;
  logic [1:0] bp_tick;
  logic [2:0] bp_bit;
  logic [7:0] bp_shift;
  logic [7:0] bp_left;
  logic [1:0] bp_kind;
  logic [6:0] bp_addr;
  logic [7:0] bp_reg;
  logic [7:0] bp_wq[$];
  logic       bp_failed;

  bus_res_t    pending_bus_results[$];
  int unsigned mismatch_count = 0;
  int unsigned work_items = 0;
  idle_mode_t  idle_mode = IDLE_NONE;

  i2c_master_sequencer #(
    .WRITE_QUEUE_DEPTH(i2cms_pkg::WQ_DEPTH_DEF)
  ) u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_req_type          (in_req_type),
    .in_transfer_kind     (in_transfer_kind),
    .in_target_address    (in_target_address),
    .in_register_index    (in_register_index),
    .in_byte_count        (in_byte_count),
    .in_write_data        (in_write_data),
    .in_sda_sampled       (in_sda_sampled),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_scl_level        (out_scl_level),
    .out_sda_level        (out_sda_level),
    .out_sda_output_enable(out_sda_output_enable),
    .out_read_data        (out_read_data),
    .out_read_valid       (out_read_valid),
    .out_transfer_done    (out_transfer_done),
    .out_transfer_ok      (out_transfer_ok),
    .out_busy_res         (out_busy_res),
    .out_data_wanted      (out_data_wanted)
  );

  // Clock with an 8 ns period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void go_phase(input i2cms_pkg::phase_t p);
    bp_phase = p;
    bp_tick  = '0;
    bp_bit   = '0;
  endfunction

  function automatic void load_byte(input i2cms_pkg::phase_t p, input logic [7:0] b);
    bp_shift = b;
    go_phase(p);
  endfunction

  // A write byte may be due: send it, wait for one, or stop when none is left.
  function automatic void write_next();
    if (bp_left == 0) begin
      go_phase(i2cms_pkg::PH_STOP);
    end else if (bp_wq.size() > 0) begin
      bp_left = bp_left - 8'd1;
      load_byte(i2cms_pkg::PH_SEND_DATA, bp_wq.pop_front());
    end else begin
      go_phase(i2cms_pkg::PH_WAIT_DATA);
    end
  endfunction

  function automatic void read_next();
    if (bp_left == 0) begin
      go_phase(i2cms_pkg::PH_STOP);
    end else begin
      bp_shift = '0;
      go_phase(i2cms_pkg::PH_READ);
    end
  endfunction

  // Advances the predicted bus by one transaction and returns its result.
  function automatic bus_res_t predict_bus_interval(input bus_item_t it);
    bus_res_t   r;
    logic [1:0] t;
    r = '0;
    t = bp_tick;
    r.busy = (bp_phase != i2cms_pkg::PH_IDLE);
    if (it.req != i2cms_pkg::REQ_TICK) begin
      if (it.req == i2cms_pkg::REQ_CMD && bp_phase == i2cms_pkg::PH_IDLE) begin
        bp_kind   = it.kind;
        bp_addr   = it.addr;
        bp_reg    = it.regi;
        bp_left   = it.count;
        bp_failed = 1'b0;
        go_phase(i2cms_pkg::PH_START_A);
      end else if (it.req == i2cms_pkg::REQ_PUSH && bp_wq.size() < i2cms_pkg::WQ_DEPTH_DEF)
      begin
        bp_wq.push_back(it.wdata);
      end
      r.busy = (bp_phase != i2cms_pkg::PH_IDLE);
    end else begin
      case (bp_phase)
        i2cms_pkg::PH_START_A, i2cms_pkg::PH_START_B: begin
          r.oe  = 1'b1;
          r.scl = (t < 2);
          r.sda = (t == 0);
          if (t >= 2) begin
            if (bp_phase == i2cms_pkg::PH_START_A)
              load_byte(i2cms_pkg::PH_SEND_ADDR_A,
                        {bp_addr, bp_kind == i2cms_pkg::KIND_READ});
            else
              load_byte(i2cms_pkg::PH_SEND_ADDR_B, {bp_addr, 1'b1});
          end else begin
            bp_tick = t + 2'd1;
          end
        end
        i2cms_pkg::PH_SEND_ADDR_A, i2cms_pkg::PH_SEND_REG,
        i2cms_pkg::PH_SEND_ADDR_B, i2cms_pkg::PH_SEND_DATA: begin
          r.oe  = 1'b1;
          r.sda = bp_shift[7];
          r.scl = (t == 1);
          if (t >= 2) begin
            bp_shift = bp_shift << 1;
            bp_tick  = '0;
            if (bp_bit == 3'd7) go_phase(i2cms_pkg::phase_t'(bp_phase + 5'd1));
            else bp_bit = bp_bit + 3'd1;
          end else begin
            bp_tick = t + 2'd1;
          end
        end
        i2cms_pkg::PH_ACK_ADDR_A, i2cms_pkg::PH_ACK_REG,
        i2cms_pkg::PH_ACK_ADDR_B, i2cms_pkg::PH_ACK_DATA: begin
          r.sda = 1'b1;
          if (t == 0) begin
            r.scl = 1'b1;
            if (it.sda) bp_failed = 1'b1;
            bp_tick = 2'd1;
          end else if (bp_failed) begin
            go_phase(i2cms_pkg::PH_STOP);
          end else if (bp_phase == i2cms_pkg::PH_ACK_ADDR_A) begin
            if (bp_kind == i2cms_pkg::KIND_READ) read_next();
            else if (bp_kind == i2cms_pkg::KIND_WRITE) write_next();
            else load_byte(i2cms_pkg::PH_SEND_REG, bp_reg);
          end else if (bp_phase == i2cms_pkg::PH_ACK_REG) begin
            if (bp_kind == i2cms_pkg::KIND_REG_READ) go_phase(i2cms_pkg::PH_START_B);
            else write_next();
          end else if (bp_phase == i2cms_pkg::PH_ACK_ADDR_B) begin
            read_next();
          end else begin
            write_next();
          end
        end
        i2cms_pkg::PH_READ: begin
          r.sda = 1'b1;
          r.scl = (t < 2);
          if (t == 1) bp_shift = {bp_shift[6:0], it.sda};
          if (t >= 2) begin
            bp_tick = '0;
            if (bp_bit == 3'd7) begin
              r.rvalid = 1'b1;
              r.rdata  = bp_shift;
              bp_left  = bp_left - 8'd1;
              go_phase(i2cms_pkg::PH_MACK);
            end else begin
              bp_bit = bp_bit + 3'd1;
            end
          end else begin
            bp_tick = t + 2'd1;
          end
        end
        i2cms_pkg::PH_MACK: begin
          // The last read byte gets a NACK.
          r.oe  = 1'b1;
          r.sda = (bp_left == 0);
          r.scl = (t == 1);
          if (t >= 2) read_next();
          else bp_tick = t + 2'd1;
        end
        i2cms_pkg::PH_STOP: begin
          r.oe  = 1'b1;
          r.scl = 1'b1;
          r.sda = (t != 0);
          if (t == 0) begin
            bp_tick = 2'd1;
          end else begin
            r.done = 1'b1;
            r.ok   = !bp_failed;
            go_phase(i2cms_pkg::PH_IDLE);
          end
        end
        i2cms_pkg::PH_WAIT_DATA: begin
          // SCL is held low until a write byte shows up.
          r.oe  = 1'b1;
          r.sda = 1'b1;
          if (bp_wq.size() == 0) r.wanted = 1'b1;
          else write_next();
        end
        default: begin
          r.scl = 1'b1;
          r.sda = 1'b1;
          go_phase(i2cms_pkg::PH_IDLE);
        end
      endcase
    end
    return r;
  endfunction

  // SDA level that the simulated target shows for the coming tick.
  function automatic logic pick_sda(input sda_mode_t mode);
    logic in_ack;
    in_ack = (bp_phase == i2cms_pkg::PH_ACK_ADDR_A) || (bp_phase == i2cms_pkg::PH_ACK_REG) ||
             (bp_phase == i2cms_pkg::PH_ACK_ADDR_B) || (bp_phase == i2cms_pkg::PH_ACK_DATA);
    case (mode)
      SDA_LOW:    return 1'b0;
      SDA_HIGH:   return 1'b1;
      SDA_ONES:   return !in_ack;
      SDA_TARGET: return in_ack ? ($urandom_range(0, 99) >= 92) : 1'($urandom);
      default:    return 1'($urandom);
    endcase
  endfunction

  function automatic bus_item_t rand_item(input logic [1:0] req);
    bus_item_t it;
    it = bus_item_t'(ITEM_W'({$urandom, $urandom}));
    it.req = req;
    return it;
  endfunction

  function automatic stim_row_t row(input logic [1:0] req, input logic [1:0] kind,
                                    input logic [6:0] addr, input logic [7:0] regi,
                                    input logic [7:0] count, input logic [7:0] wdata,
                                    input sda_mode_t sda, input int unsigned reps,
                                    input logic typed, input bus_res_t want);
    stim_row_t s;
    s.item  = '{req: req, kind: kind, addr: addr, regi: regi, count: count,
                wdata: wdata, sda: 1'b0};
    s.reps  = reps;
    s.sda   = sda;
    s.typed = typed;
    s.want  = want;
    return s;
  endfunction

  // Offers one transaction from a falling edge and returns at the falling edge
  // after it was accepted.
  task automatic send_item(input bus_item_t it, input logic typed, input bus_res_t want);
    bus_res_t pred;
    logic     ignored;
    while ((idle_mode == IDLE_SENDER && $urandom_range(0, 99) < 69) ||
           (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 10)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid          <= 1'b1;
    in_req_type       <= it.req;
    in_transfer_kind  <= it.kind;
    in_target_address <= it.addr;
    in_register_index <= it.regi;
    in_byte_count     <= it.count;
    in_write_data     <= it.wdata;
    in_sda_sampled    <= it.sda;
    do @(posedge clk); while (!in_ready);
    ignored = (it.req == REQ_NONE) ||
              (it.req == i2cms_pkg::REQ_CMD && bp_phase != i2cms_pkg::PH_IDLE) ||
              (it.req == i2cms_pkg::REQ_PUSH && bp_wq.size() >= i2cms_pkg::WQ_DEPTH_DEF);
    if (!ignored) work_items++;
    pred = predict_bus_interval(it);
    pending_bus_results.push_back(typed ? want : pred);
    @(negedge clk);
  endtask

  // One randomized transfer with pushes and noise mixed into its ticks.
  task automatic random_transfer();
    bus_item_t   it;
    sda_mode_t   resp;
    int unsigned roll;
    // Loose write bytes first, sometimes more than the queue holds.
    repeat ($urandom_range(0, 5)) send_item(rand_item(i2cms_pkg::REQ_PUSH), 1'b0, RES_NONE);
    resp = ($urandom_range(0, 99) < 90) ? SDA_TARGET : SDA_NOISE;
    it   = rand_item(i2cms_pkg::REQ_CMD);
    roll = $urandom_range(0, 99);
    if (roll < 30) begin
      it.count = 8'($urandom_range(4, 12));
    end else begin
      it.count = 8'($urandom_range(0, 3));
    end
    send_item(it, 1'b0, RES_NONE);
    while (bp_phase != i2cms_pkg::PH_IDLE) begin
      roll = $urandom_range(0, 99);
      if ((bp_phase == i2cms_pkg::PH_WAIT_DATA && roll < 40) || roll < 6) begin
        send_item(rand_item(i2cms_pkg::REQ_PUSH), 1'b0, RES_NONE);
      end else if (roll < 9) begin
        send_item(rand_item(i2cms_pkg::REQ_CMD), 1'b0, RES_NONE);
      end else if (roll < 11) begin
        send_item(rand_item(REQ_NONE), 1'b0, RES_NONE);
      end else begin
        it     = rand_item(i2cms_pkg::REQ_TICK);
        it.sda = pick_sda(resp);
        send_item(it, 1'b0, RES_NONE);
      end
    end
    // A few idle ticks or no-op transactions between transfers.
    repeat ($urandom_range(0, 3))
      send_item(rand_item(($urandom_range(0, 3) == 0) ? REQ_NONE : i2cms_pkg::REQ_TICK),
                1'b0, RES_NONE);
  endtask

  // Receiver stalls according to the current idle pattern.
  always @(negedge clk) begin
    case (idle_mode)
      IDLE_RECEIVER: out_ready <= ($urandom_range(0, 99) >= 69);
      IDLE_BOTH:     out_ready <= ($urandom_range(0, 99) >= 10);
      default:       out_ready <= 1'b1;
    endcase
  end

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  // Compare each accepted result transaction with the oldest prediction.
  always @(posedge clk) begin : result_check
    bus_res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_bus_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: result transaction with none expected, expected nothing, got scl=%b",
                 $time, out_scl_level);
      end else begin
        want = pending_bus_results.pop_front();
        check_field("scl_level", 8'(want.scl), 8'(out_scl_level));
        check_field("sda_level", 8'(want.sda), 8'(out_sda_level));
        check_field("sda_output_enable", 8'(want.oe), 8'(out_sda_output_enable));
        check_field("read_data", want.rdata, out_read_data);
        check_field("read_valid", 8'(want.rvalid), 8'(out_read_valid));
        check_field("transfer_done", 8'(want.done), 8'(out_transfer_done));
        check_field("transfer_ok", 8'(want.ok), 8'(out_transfer_ok));
        check_field("busy_res", 8'(want.busy), 8'(out_busy_res));
        check_field("data_wanted", 8'(want.wanted), 8'(out_data_wanted));
      end
    end
  end

  // Stimulus: reset, directed table, randomized transfers, then drain.
  initial begin
    stim_row_t dir_rows[$];
    bus_item_t it;
    bp_wq.delete();
    bp_shift  = '0;
    bp_left   = '0;
    bp_kind   = '0;
    bp_addr   = '0;
    bp_reg    = '0;
    bp_failed = 1'b0;
    go_phase(i2cms_pkg::PH_IDLE);

    // Idle bus, no-op, queue filled past its depth, command while busy.
    dir_rows.push_back(row(i2cms_pkg::REQ_TICK, 2'd0, 7'h00, 8'h00, 8'h00, 8'h00, SDA_LOW, 2,
                           1'b1, RES_IDLE_BUS));
    dir_rows.push_back(row(REQ_NONE, i2cms_pkg::KIND_REG_WRITE, 7'h7F, 8'hFF, 8'hFF, 8'hFF,
                           SDA_HIGH, 1, 1'b1, RES_NONE));
    dir_rows.push_back(row(i2cms_pkg::REQ_PUSH, 2'd0, 7'h00, 8'h00, 8'h00, 8'hA5, SDA_LOW, 1,
                           1'b1, RES_NONE));
    dir_rows.push_back(row(i2cms_pkg::REQ_PUSH, 2'd0, 7'h00, 8'h00, 8'h00, 8'h5A, SDA_LOW, 1,
                           1'b1, RES_NONE));
    dir_rows.push_back(row(i2cms_pkg::REQ_PUSH, 2'd0, 7'h00, 8'h00, 8'h00, 8'hFF, SDA_LOW, 1,
                           1'b1, RES_NONE));
    dir_rows.push_back(row(i2cms_pkg::REQ_PUSH, 2'd0, 7'h00, 8'h00, 8'h00, 8'h00, SDA_LOW, 1,
                           1'b1, RES_NONE));
    dir_rows.push_back(row(i2cms_pkg::REQ_PUSH, 2'd0, 7'h00, 8'h00, 8'h00, 8'h3C, SDA_LOW, 1,
                           1'b1, RES_NONE));
    dir_rows.push_back(row(i2cms_pkg::REQ_CMD, i2cms_pkg::KIND_WRITE, 7'h7F, 8'h00, 8'd2, 8'h00,
                           SDA_LOW, 1, 1'b1, RES_BUSY));
    dir_rows.push_back(row(i2cms_pkg::REQ_CMD, i2cms_pkg::KIND_READ, 7'h00, 8'hFF, 8'hFF, 8'h00,
                           SDA_LOW, 1, 1'b1, RES_BUSY));
    dir_rows.push_back(row(i2cms_pkg::REQ_TICK, 2'd0, 7'h00, 8'h00, 8'h00, 8'h00, SDA_LOW, 1,
                           1'b1, RES_START_OPEN));
    dir_rows.push_back(row(i2cms_pkg::REQ_TICK, 2'd0, 7'h00, 8'h00, 8'h00, 8'h00, SDA_LOW, 90,
                           1'b0, RES_NONE));
    // Register write that runs the queue dry and pauses the bus.
    dir_rows.push_back(row(i2cms_pkg::REQ_CMD, i2cms_pkg::KIND_REG_WRITE, 7'h00, 8'hFF, 8'd3,
                           8'h00, SDA_LOW, 1, 1'b1, RES_BUSY));
    dir_rows.push_back(row(i2cms_pkg::REQ_TICK, 2'd0, 7'h00, 8'h00, 8'h00, 8'h00, SDA_LOW, 130,
                           1'b0, RES_NONE));
    dir_rows.push_back(row(i2cms_pkg::REQ_PUSH, 2'd0, 7'h00, 8'h00, 8'h00, 8'h81, SDA_LOW, 1,
                           1'b0, RES_NONE));
    dir_rows.push_back(row(i2cms_pkg::REQ_TICK, 2'd0, 7'h00, 8'h00, 8'h00, 8'h00, SDA_LOW, 40,
                           1'b0, RES_NONE));
    // Zero byte count read.
    dir_rows.push_back(row(i2cms_pkg::REQ_CMD, i2cms_pkg::KIND_READ, 7'h55, 8'h00, 8'd0, 8'h00,
                           SDA_LOW, 1, 1'b0, RES_NONE));
    dir_rows.push_back(row(i2cms_pkg::REQ_TICK, 2'd0, 7'h00, 8'h00, 8'h00, 8'h00, SDA_LOW, 40,
                           1'b0, RES_NONE));
    // Target NACKs the address of a long write.
    dir_rows.push_back(row(i2cms_pkg::REQ_CMD, i2cms_pkg::KIND_WRITE, 7'h2A, 8'h00, 8'hFF,
                           8'h00, SDA_LOW, 1, 1'b0, RES_NONE));
    dir_rows.push_back(row(i2cms_pkg::REQ_TICK, 2'd0, 7'h00, 8'h00, 8'h00, 8'h00, SDA_HIGH, 40,
                           1'b0, RES_NONE));
    // Read of all-ones bytes, then a register read with a repeated start.
    dir_rows.push_back(row(i2cms_pkg::REQ_CMD, i2cms_pkg::KIND_READ, 7'h33, 8'h00, 8'd2, 8'h00,
                           SDA_LOW, 1, 1'b0, RES_NONE));
    dir_rows.push_back(row(i2cms_pkg::REQ_TICK, 2'd0, 7'h00, 8'h00, 8'h00, 8'h00, SDA_ONES, 100,
                           1'b0, RES_NONE));
    dir_rows.push_back(row(i2cms_pkg::REQ_CMD, i2cms_pkg::KIND_REG_READ, 7'h12, 8'h34, 8'd1,
                           8'h00, SDA_LOW, 1, 1'b0, RES_NONE));
    dir_rows.push_back(row(i2cms_pkg::REQ_TICK, 2'd0, 7'h00, 8'h00, 8'h00, 8'h00, SDA_TARGET,
                           130, 1'b0, RES_NONE));
    dir_rows.push_back(row(i2cms_pkg::REQ_TICK, 2'd0, 7'h00, 8'h00, 8'h00, 8'h00, SDA_LOW, 1,
                           1'b0, RES_NONE));

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      repeat (dir_rows[i].reps) begin
        it     = dir_rows[i].item;
        it.sda = pick_sda(dir_rows[i].sda);
        send_item(it, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    // Random transfers under each idle pattern, ending with none.
    work_items = 0;
    for (int p = 0; p < IDLE_PHASES; p++) begin
      idle_mode = idle_mode_t'(p % 4);
      while (work_items < (p + 1) * (RANDOM_ITEMS / IDLE_PHASES)) random_transfer();
    end
    in_valid <= 1'b0;

    while (pending_bus_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #10000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
